// ----- hw/rtl/ede_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Edit distance engine package
// Shared sizes, input mode codes, controller states and the cell control
// bundle for the edit distance engine.
// ----------------------------------------------------------------------------
package ede_pkg;

	localparam int MAX_LEN = 32;
	localparam int CNT_W   = $clog2(MAX_LEN + 1);
	localparam int ADDR_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int SYM_W   = 8;
	localparam int DIST_W  = 6;
	localparam int MODE_W  = 2;

	localparam logic [MODE_W-1:0] MODE_FIRST   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SECOND  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_COMPUTE = 2'd2;

	localparam logic [CNT_W+DIST_W-1:0] DIST_MAX = (CNT_W + DIST_W)'((1 << DIST_W) - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROW,
		ST_CELL,
		ST_FINISH,
		ST_EMIT
	} state_t;

	// Control for one cell issue: the row and column being read this cycle.
	typedef struct packed {
		logic             issue;
		logic             init;
		logic             first_row;
		logic [CNT_W-1:0] row;
		logic [CNT_W-1:0] col;
	} cell_ctl_t;

	function automatic logic [DIST_W-1:0] sat_dist(input logic [CNT_W-1:0] v);
		logic [CNT_W+DIST_W-1:0] w;
		w = {{DIST_W{1'b0}}, v};
		if (w > DIST_MAX)
			return DIST_MAX[DIST_W-1:0];
		return w[DIST_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/ede_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port; the read data is registered and holds
// its value until the next read.
// ----------------------------------------------------------------------------
module ede_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                                      clk,
	input  wire logic                                      we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                          wdata,
	input  wire logic                                      re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ----- hw/rtl/ede_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Edit distance cost cell
// Takes the registered cost row entry and the two registered symbols,
// forms the minimum of the three edit paths and writes it back.
// ----------------------------------------------------------------------------
module ede_cell (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire ede_pkg::cell_ctl_t         ctl,
	input  wire logic [ede_pkg::SYM_W-1:0]  sym_a,
	input  wire logic [ede_pkg::SYM_W-1:0]  sym_b,
	input  wire logic [ede_pkg::CNT_W-1:0]  up_rd,
	output logic                            wr_en,
	output logic [ede_pkg::ADDR_W-1:0]      wr_addr,
	output logic [ede_pkg::CNT_W-1:0]       cell_value
);

	logic                        valid_s1;
	logic                        first_row_s1;
	logic [ede_pkg::CNT_W-1:0]   col_s1;
	logic [ede_pkg::CNT_W-1:0]   diag_q;
	logic [ede_pkg::CNT_W-1:0]   left_q;
	logic [ede_pkg::CNT_W-1:0]   up;
	logic [ede_pkg::CNT_W-1:0]   col_m1;
	logic [ede_pkg::CNT_W:0]     up_p1;
	logic [ede_pkg::CNT_W:0]     left_p1;
	logic [ede_pkg::CNT_W:0]     sub;
	logic [ede_pkg::CNT_W:0]     best;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= ctl.issue;
		end
	end

	always_ff @(posedge clk) begin
		first_row_s1 <= ctl.first_row;
		col_s1       <= ctl.col;
		// The start of a row never coincides with a cell in flight.
		if (ctl.init) begin
			diag_q <= ctl.row - ede_pkg::CNT_W'(1);
			left_q <= ctl.row;
		end else if (valid_s1) begin
			diag_q <= up;
			left_q <= cell_value;
		end
	end

	always_comb begin
		// The memory read is ignored on the first row: its entries equal the column.
		up      = first_row_s1 ? col_s1 : up_rd;
		up_p1   = {1'b0, up} + (ede_pkg::CNT_W + 1)'(1);
		left_p1 = {1'b0, left_q} + (ede_pkg::CNT_W + 1)'(1);
		sub     = {1'b0, diag_q} + (ede_pkg::CNT_W + 1)'(sym_a != sym_b);
		best    = (up_p1 < left_p1) ? up_p1 : left_p1;
		if (sub < best)
			best = sub;
		cell_value = best[ede_pkg::CNT_W-1:0];
		col_m1     = col_s1 - ede_pkg::CNT_W'(1);
		wr_addr    = col_m1[ede_pkg::ADDR_W-1:0];
		wr_en      = valid_s1;
	end

endmodule
`default_nettype wire

// ----- hw/rtl/edit_distance_engine_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Edit distance engine
// Loads two byte strings symbol by symbol and returns their Levenshtein
// distance from a single cost row held in RAM.
//
//   Channel  Direction  Signals                         Content
//   in       input      in_valid, in_ready, mode, symbol  load or compute command
//   out      output     out_valid, out_ready, distance, overflow  one result per compute
//
// A load is taken in ST_IDLE and leaves the engine idle. A compute with both
// lengths non-zero serves one cell per cycle in ST_CELL from the cost row
// RAM, with a ST_ROW step per row to fetch the first-string symbol, then
// ST_FINISH and ST_EMIT; with an empty string it goes straight to ST_EMIT.
// Reset clears the lengths, the dropped flag and the output valid flag; no clearing pass.
// Loads are taken while a result waits; a compute waits in its last state
// until the output register is free.
// ----------------------------------------------------------------------------
module edit_distance_engine_top (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [ede_pkg::MODE_W-1:0]  mode,
	input  wire logic [ede_pkg::SYM_W-1:0]   symbol,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [ede_pkg::DIST_W-1:0]       distance,
	output logic                             overflow
);

	ede_pkg::state_t            state_q, state_d;
	logic [ede_pkg::CNT_W-1:0]  len1_q, len2_q;
	logic [ede_pkg::CNT_W-1:0]  row_q, row_d;
	logic [ede_pkg::CNT_W-1:0]  col_q, col_d;
	logic [ede_pkg::CNT_W-1:0]  res_q, res_d;
	logic                       drop_q;
	logic                       out_valid_q;
	logic [ede_pkg::DIST_W-1:0] distance_q;
	logic                       overflow_q;

	logic                       in_fire;
	logic                       load1, load2, drop_set;
	logic                       emit_go;
	ede_pkg::cell_ctl_t         ctl;
	logic [ede_pkg::CNT_W-1:0]  row_m1, col_m1;
	logic [ede_pkg::SYM_W-1:0]  sym_a, sym_b;
	logic [ede_pkg::CNT_W-1:0]  up_rd, cell_value;
	logic                       cost_we;
	logic [ede_pkg::ADDR_W-1:0] cost_waddr;
	logic                       fs_re;

	assign in_ready  = (state_q == ede_pkg::ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign distance  = distance_q;
	assign overflow  = overflow_q;
	assign row_m1    = row_q - ede_pkg::CNT_W'(1);
	assign col_m1    = col_q - ede_pkg::CNT_W'(1);

	always_comb begin
		state_d  = state_q;
		row_d    = row_q;
		col_d    = col_q;
		res_d    = res_q;
		load1    = 1'b0;
		load2    = 1'b0;
		drop_set = 1'b0;
		emit_go  = 1'b0;
		fs_re    = 1'b0;
		ctl      = '0;
		ctl.row       = row_q;
		ctl.col       = col_q;
		ctl.first_row = (row_q == ede_pkg::CNT_W'(1));
		unique case (state_q)
			ede_pkg::ST_IDLE: begin
				if (in_fire) begin
					if (mode == ede_pkg::MODE_FIRST) begin
						if (len1_q < ede_pkg::CNT_W'(ede_pkg::MAX_LEN))
							load1 = 1'b1;
						else
							drop_set = 1'b1;
					end else if (mode == ede_pkg::MODE_SECOND) begin
						if (len2_q < ede_pkg::CNT_W'(ede_pkg::MAX_LEN))
							load2 = 1'b1;
						else
							drop_set = 1'b1;
					end else if (mode == ede_pkg::MODE_COMPUTE) begin
						// An empty string gives the other string's length at once.
						if (len1_q == '0) begin
							res_d   = len2_q;
							state_d = ede_pkg::ST_EMIT;
						end else if (len2_q == '0) begin
							res_d   = len1_q;
							state_d = ede_pkg::ST_EMIT;
						end else begin
							row_d   = ede_pkg::CNT_W'(1);
							state_d = ede_pkg::ST_ROW;
						end
					end
				end
			end
			ede_pkg::ST_ROW: begin
				fs_re   = 1'b1;
				col_d   = ede_pkg::CNT_W'(1);
				state_d = ede_pkg::ST_CELL;
			end
			ede_pkg::ST_CELL: begin
				ctl.issue = 1'b1;
				ctl.init  = (col_q == ede_pkg::CNT_W'(1));
				col_d     = col_q + ede_pkg::CNT_W'(1);
				if (col_q == len2_q) begin
					if (row_q == len1_q) begin
						state_d = ede_pkg::ST_FINISH;
					end else begin
						row_d   = row_q + ede_pkg::CNT_W'(1);
						state_d = ede_pkg::ST_ROW;
					end
				end
			end
			ede_pkg::ST_FINISH: begin
				res_d   = cell_value;
				state_d = ede_pkg::ST_EMIT;
			end
			ede_pkg::ST_EMIT: begin
				if (!out_valid_q || out_ready) begin
					emit_go = 1'b1;
					state_d = ede_pkg::ST_IDLE;
				end
			end
			default: state_d = ede_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ede_pkg::ST_IDLE;
			len1_q      <= '0;
			len2_q      <= '0;
			drop_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit_go) begin
				len1_q <= '0;
				len2_q <= '0;
				drop_q <= 1'b0;
			end else begin
				if (load1)
					len1_q <= len1_q + ede_pkg::CNT_W'(1);
				if (load2)
					len2_q <= len2_q + ede_pkg::CNT_W'(1);
				if (drop_set)
					drop_q <= 1'b1;
			end
			if (emit_go)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		row_q <= row_d;
		col_q <= col_d;
		res_q <= res_d;
		if (emit_go) begin
			distance_q <= ede_pkg::sat_dist(res_q);
			overflow_q <= drop_q;
		end
	end

	ede_ram #(
		.WIDTH(ede_pkg::SYM_W),
		.DEPTH(ede_pkg::MAX_LEN)
	) u_first_ram (
		.clk  (clk),
		.we   (load1),
		.waddr(len1_q[ede_pkg::ADDR_W-1:0]),
		.wdata(symbol),
		.re   (fs_re),
		.raddr(row_m1[ede_pkg::ADDR_W-1:0]),
		.rdata(sym_a)
	);

	ede_ram #(
		.WIDTH(ede_pkg::SYM_W),
		.DEPTH(ede_pkg::MAX_LEN)
	) u_second_ram (
		.clk  (clk),
		.we   (load2),
		.waddr(len2_q[ede_pkg::ADDR_W-1:0]),
		.wdata(symbol),
		.re   (ctl.issue),
		.raddr(col_m1[ede_pkg::ADDR_W-1:0]),
		.rdata(sym_b)
	);

	// Entry j of the cost row lives at address j - 1; column zero is implied.
	ede_ram #(
		.WIDTH(ede_pkg::CNT_W),
		.DEPTH(ede_pkg::MAX_LEN)
	) u_cost_ram (
		.clk  (clk),
		.we   (cost_we),
		.waddr(cost_waddr),
		.wdata(cell_value),
		.re   (ctl.issue),
		.raddr(col_m1[ede_pkg::ADDR_W-1:0]),
		.rdata(up_rd)
	);

	ede_cell u_cell (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.sym_a     (sym_a),
		.sym_b     (sym_b),
		.up_rd     (up_rd),
		.wr_en     (cost_we),
		.wr_addr   (cost_waddr),
		.cell_value(cell_value)
	);

endmodule
`default_nettype wire

// ----- tb/tb_edit_distance_engine_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edit distance engine testbench
// Loads pairs of byte strings, asks for their Levenshtein distance and checks
// every result against an in-bench dynamic programming predictor, or against
// the fixed result of a scripted row. A short scripted part covers empty and
// full strings, the ignored mode and the extreme symbols; random sequences of
// loads and computes follow, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_edit_distance_engine_top;
	import ede_pkg::*;

	localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;
	localparam int DIST_LIMIT     = (1 << DIST_W) - 1;
	localparam int LOAD_TARGET    = 1600;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 50;
	localparam int SCRIPT_ROWS    = 26;

	typedef struct packed {
		logic [DIST_W-1:0] dist_val;
		logic              ov;
	} result_t;

	typedef struct packed {
		logic [MODE_W-1:0] op;
		logic [SYM_W-1:0]  sym;
		logic [5:0]        rep;
		logic              fixed;
		logic [DIST_W-1:0] dist_val;
		logic              ov;
	} script_row_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [MODE_W-1:0] mode;
	logic [SYM_W-1:0]  symbol;
	logic              out_valid;
	logic              out_ready;
	logic [DIST_W-1:0] distance;
	logic              overflow;

	logic [SYM_W-1:0] first_syms [MAX_LEN];
	logic [SYM_W-1:0] second_syms [MAX_LEN];
	int               first_len = 0;
	int               second_len = 0;
	bit               dropped = 1'b0;

	result_t pending_results [$];
	int      mismatches = 0;
	int      work_items = 0;
	int      idle_cycles = 0;
	bit      calm = 1'b0;

	// Rows with fixed set carry a distance that is obvious from the strings.
	script_row_t script [0:SCRIPT_ROWS-1] = '{
		'{MODE_COMPUTE, 8'h00, 6'd1,  1'b1, 6'd0,  1'b0},
		'{MODE_NONE,    8'hA5, 6'd1,  1'b0, 6'd0,  1'b0},
		'{MODE_COMPUTE, 8'h00, 6'd1,  1'b1, 6'd0,  1'b0},
		'{MODE_FIRST,   8'h00, 6'd1,  1'b0, 6'd0,  1'b0},
		'{MODE_FIRST,   8'hFF, 6'd1,  1'b0, 6'd0,  1'b0},
		'{MODE_COMPUTE, 8'h00, 6'd1,  1'b1, 6'd2,  1'b0},
		'{MODE_SECOND,  8'hFF, 6'd1,  1'b0, 6'd0,  1'b0},
		'{MODE_SECOND,  8'h00, 6'd1,  1'b0, 6'd0,  1'b0},
		'{MODE_SECOND,  8'h5A, 6'd1,  1'b0, 6'd0,  1'b0},
		'{MODE_COMPUTE, 8'h3C, 6'd1,  1'b1, 6'd3,  1'b0},
		'{MODE_FIRST,   8'h00, 6'd1,  1'b0, 6'd0,  1'b0},
		'{MODE_SECOND,  8'h00, 6'd1,  1'b0, 6'd0,  1'b0},
		'{MODE_COMPUTE, 8'h00, 6'd1,  1'b1, 6'd0,  1'b0},
		'{MODE_FIRST,   8'h12, 6'd1,  1'b0, 6'd0,  1'b0},
		'{MODE_FIRST,   8'h34, 6'd1,  1'b0, 6'd0,  1'b0},
		'{MODE_NONE,    8'h34, 6'd1,  1'b0, 6'd0,  1'b0},
		'{MODE_SECOND,  8'h34, 6'd1,  1'b0, 6'd0,  1'b0},
		'{MODE_SECOND,  8'h12, 6'd1,  1'b0, 6'd0,  1'b0},
		'{MODE_SECOND,  8'h56, 6'd1,  1'b0, 6'd0,  1'b0},
		'{MODE_COMPUTE, 8'hFF, 6'd1,  1'b0, 6'd0,  1'b0},
		'{MODE_FIRST,   8'hFF, 6'd33, 1'b0, 6'd0,  1'b0},
		'{MODE_COMPUTE, 8'h00, 6'd1,  1'b1, 6'd32, 1'b1},
		'{MODE_SECOND,  8'h00, 6'd33, 1'b0, 6'd0,  1'b0},
		'{MODE_FIRST,   8'h00, 6'd1,  1'b0, 6'd0,  1'b0},
		'{MODE_COMPUTE, 8'h00, 6'd1,  1'b1, 6'd31, 1'b1},
		'{MODE_COMPUTE, 8'h00, 6'd1,  1'b1, 6'd0,  1'b0}
	};

	edit_distance_engine_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.symbol    (symbol),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.distance  (distance),
		.overflow  (overflow)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Single-row Levenshtein sweep over the strings loaded so far.
	function automatic int edit_cost();
		int row [MAX_LEN+1];
		int diag;
		int up;
		int cand;
		for (int j = 0; j <= second_len; j++)
			row[j] = j;
		for (int i = 1; i <= first_len; i++) begin
			diag = row[0];
			row[0] = i;
			for (int j = 1; j <= second_len; j++) begin
				up = row[j];
				cand = diag + ((first_syms[i-1] != second_syms[j-1]) ? 1 : 0);
				if (up + 1 < cand)
					cand = up + 1;
				if (row[j-1] + 1 < cand)
					cand = row[j-1] + 1;
				row[j] = cand;
				diag = up;
			end
		end
		return row[second_len];
	endfunction

	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return $urandom_range(0, 6);
		if (r < 92)
			return $urandom_range(7, MAX_LEN - 1);
		return $urandom_range(MAX_LEN, MAX_LEN + 3);
	endfunction

	// Offers one item, waits for its transfer and then updates the predicted
	// state. A fixed result replaces the predicted one for scripted rows.
	task automatic put_item(input logic [MODE_W-1:0] m, input logic [SYM_W-1:0] s,
			input logic fixed, input logic [DIST_W-1:0] fdist, input logic fov);
		int gap;
		int cost;
		result_t r;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode     <= m;
		symbol   <= s;
		do @(posedge clk); while (!in_ready);
		case (m)
			MODE_FIRST: begin
				if (first_len < MAX_LEN) begin
					first_syms[first_len] = s;
					first_len++;
				end else begin
					dropped = 1'b1;
				end
			end
			MODE_SECOND: begin
				if (second_len < MAX_LEN) begin
					second_syms[second_len] = s;
					second_len++;
				end else begin
					dropped = 1'b1;
				end
			end
			MODE_COMPUTE: begin
				cost = edit_cost();
				if (cost > DIST_LIMIT)
					cost = DIST_LIMIT;
				r.dist_val = cost[DIST_W-1:0];
				r.ov       = dropped;
				if (fixed) begin
					r.dist_val = fdist;
					r.ov       = fov;
				end
				pending_results = {pending_results, r};
				first_len  = 0;
				second_len = 0;
				dropped    = 1'b0;
			end
			default: ;
		endcase
		if (m != MODE_NONE)
			work_items++;
	endtask

	// Drops valid and holds the sender back until every result has arrived.
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic random_sequence();
		int n1;
		int n2;
		int l1;
		int l2;
		bit narrow;
		logic [SYM_W-1:0] base;
		logic [SYM_W-1:0] s;
		n1 = pick_len();
		n2 = pick_len();
		l1 = 0;
		l2 = 0;
		narrow = 1'($urandom_range(0, 1));
		base = SYM_W'($urandom_range(0, 255));
		while (l1 < n1 || l2 < n2) begin
			// A narrow alphabet makes matching symbols, and so short distances, common.
			s = narrow ? (base ^ SYM_W'($urandom_range(0, 3))) : SYM_W'($urandom_range(0, 255));
			if ($urandom_range(0, 19) == 0)
				put_item(MODE_NONE, s, 1'b0, '0, 1'b0);
			else if (l2 >= n2 || (l1 < n1 && $urandom_range(0, 1) == 0)) begin
				put_item(MODE_FIRST, s, 1'b0, '0, 1'b0);
				l1++;
			end else begin
				put_item(MODE_SECOND, s, 1'b0, '0, 1'b0);
				l2++;
			end
		end
		// Now and then the strings are left to grow into the next sequence.
		if ($urandom_range(0, 9) != 0)
			put_item(MODE_COMPUTE, SYM_W'($urandom_range(0, 255)), 1'b0, '0, 1'b0);
	endtask

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		mode      = MODE_FIRST;
		symbol    = '0;
		out_ready = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[k])
			for (int n = 0; n < script[k].rep; n++)
				put_item(script[k].op, script[k].sym, script[k].fixed,
					script[k].dist_val, script[k].ov);
		drain_results();

		while (work_items < LOAD_TARGET) begin
			if ($urandom_range(0, 6) == 0)
				calm = ~calm;
			if ($urandom_range(0, 24) == 0)
				drain_results();
			random_sequence();
		end
		put_item(MODE_COMPUTE, 8'h00, 1'b0, '0, 1'b0);

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		int gap;
		wait (arst_n);
		@(posedge clk);
		forever begin
			gap = pick_gap();
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result transfer with nothing expected, distance %0d overflow %0d",
					$time, distance, overflow);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (distance !== want.dist_val) begin
					$display("%0t: distance expected %0d, got %0d", $time, want.dist_val,
						distance);
					mismatches++;
				end
				if (overflow !== want.ov) begin
					$display("%0t: overflow expected %0d, got %0d", $time, want.ov, overflow);
					mismatches++;
				end
			end
		end
	end

	// A long compute leaves both channels quiet, so the limit is well above it.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

endmodule

// ----- edit_distance_engine_top.f -----
hw/rtl/ede_pkg.sv
hw/rtl/ede_ram.sv
hw/rtl/ede_cell.sv
hw/rtl/edit_distance_engine_top.sv
tb/tb_edit_distance_engine_top.sv
